[rtl/bmtp_pkg.sv]
// bmtp_pkg: record layout constants, result kinds and result types shared by the
// binary mesh triangle parser and its response queue. No dependencies.
package bmtp_pkg;

   localparam int unsigned RECORD_BYTES = 50;
   localparam int unsigned NORMAL_BYTES = 12;
   localparam int unsigned COUNT_BYTES  = 4;
   localparam int unsigned VERTEX_WORDS = 9;
   localparam int unsigned VERTEX_END   = NORMAL_BYTES + 4 * VERTEX_WORDS;
   localparam int unsigned RECORD_W     = $clog2(RECORD_BYTES);
   localparam int unsigned VIDX_W       = $clog2(VERTEX_WORDS);
   localparam int unsigned QUEUE_DEPTH  = 4;

   typedef enum logic [1:0] {
      KIND_TRIANGLE   = 2'd0,
      KIND_SUCCESS    = 2'd1,
      KIND_SIZE_ERROR = 2'd2,
      KIND_NONFINITE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [VERTEX_WORDS-1:0][31:0] vertex;
      kind_type                      kind;
      logic [31:0]                   number;
      logic                          last;
   } result_type;

   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic word_finite(input logic [31:0] w);
      return w[30:23] != 8'hFF;
   endfunction

endpackage

[rtl/bmtp_rsp_queue.sv]
// bmtp_rsp_queue: small response queue taking up to two results per cycle
// and handing out one per cycle while out_ready is high. Depends on bmtp_pkg.
module bmtp_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  bmtp_pkg::push_type   push,
   output logic                 space_ok,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bmtp_pkg::result_type out_data
);

   localparam int unsigned PTR_W = $clog2(bmtp_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(bmtp_pkg::QUEUE_DEPTH + 1);

   bmtp_pkg::result_type entry_ff [bmtp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     n_push;
   logic                 pop;

   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign space_ok  = count_ff <= CNT_W'(bmtp_pkg::QUEUE_DEPTH - 2);
   assign pop       = out_valid & out_ready;

   always_comb begin
      n_push    = CNT_W'(push.first_valid) + CNT_W'(push.second_valid);
      count_in  = count_ff + n_push - CNT_W'(pop);
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

[rtl/binary_mesh_triangle_parser.sv]
// binary_mesh_triangle_parser: byte-serial parser for binary triangle mesh files.
// Depends on bmtp_pkg and bmtp_rsp_queue.
//
// channel  direction  tdata                                 tuser        tlast
// req      in         data_byte                             -            final_byte
// rsp      out        v0_x..v2_z, triangle_number           result_kind  end_of_run
//
// one byte per cycle unless req_tready is low; each updates counters and word shifter
// results go into a four-entry queue, up to two per byte (triangle plus status)
// req_tready drops only while the queue holds more than two results
// reset is synchronous and clears parse state (not vertex registers) and the queue
module binary_mesh_triangle_parser #(
   parameter int unsigned HEADER_BYTES = 80
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [319:0] rsp_tdata,   // v0_x, v0_y, v0_z, v1_x .. v2_z, triangle_number
   output logic [1:0]   rsp_tuser,   // [1:0] result_kind
   output logic         rsp_tlast
);

   localparam int unsigned PREFIX_TOTAL = HEADER_BYTES + bmtp_pkg::COUNT_BYTES;
   localparam int unsigned PW           = $clog2(PREFIX_TOTAL + 1);
   localparam int unsigned RW           = bmtp_pkg::RECORD_W;
   localparam int unsigned NV           = bmtp_pkg::VERTEX_WORDS;

   logic [PW-1:0]   prefix_ff, prefix_in;
   logic [RW-1:0]   record_ff, record_in;
   logic [31:0]     count_ff, count_in;
   logic [32:0]     done_ff, done_in;
   logic [23:0]     gather_ff, gather_in;
   logic [31:0]     vertex_ff [NV];
   logic [31:0]     vertex_in [NV];
   logic            bad_ff, bad_in;
   logic [31:0]     bad_idx_ff, bad_idx_in;

   logic            accept;
   logic [RW-1:0]   k;
   logic            all_finite;
   logic            tri_valid;
   logic            size_ok;
   bmtp_pkg::result_type tri_res, status_res, head;
   bmtp_pkg::push_type   push;
   logic            space_ok;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = space_ok;

   always_comb begin
      all_finite = 1'b1;
      for (int i = 0; i < NV; i++) begin
         if (!bmtp_pkg::word_finite(vertex_ff[i])) begin
            all_finite = 1'b0;
         end
      end
   end

   always_comb begin
      prefix_in  = prefix_ff;
      record_in  = record_ff;
      count_in   = count_ff;
      done_in    = done_ff;
      gather_in  = gather_ff;
      bad_in     = bad_ff;
      bad_idx_in = bad_idx_ff;
      for (int i = 0; i < NV; i++) begin
         vertex_in[i] = vertex_ff[i];
      end
      tri_valid  = 1'b0;
      k          = record_ff - RW'(bmtp_pkg::NORMAL_BYTES);

      if (prefix_ff < PW'(PREFIX_TOTAL)) begin
         if (prefix_ff >= PW'(HEADER_BYTES)) begin
            if (prefix_ff == PW'(PREFIX_TOTAL - 1)) begin
               count_in = {req_tdata, gather_ff};
            end else begin
               gather_in = {req_tdata, gather_ff[23:8]};
            end
         end
         prefix_in = prefix_ff + PW'(1);
      end else begin
         if (record_ff >= RW'(bmtp_pkg::NORMAL_BYTES) &&
             record_ff < RW'(bmtp_pkg::VERTEX_END)) begin
            if (k[1:0] == 2'd3) begin
               vertex_in[k[RW-1:2]] = {req_tdata, gather_ff};
            end else begin
               gather_in = {req_tdata, gather_ff[23:8]};
            end
         end
         if (record_ff == RW'(bmtp_pkg::RECORD_BYTES - 1)) begin
            record_in = '0;
            if (!bad_ff) begin
               if (all_finite) begin
                  tri_valid = 1'b1;
               end else begin
                  bad_in     = 1'b1;
                  bad_idx_in = done_ff[31:0];
               end
            end
            if (done_ff != '1) begin
               done_in = done_ff + 33'd1;
            end
         end else begin
            record_in = record_ff + RW'(1);
         end
      end

      size_ok = prefix_in >= PW'(PREFIX_TOTAL) && record_in == '0 &&
                done_in == {1'b0, count_in};

      tri_res.vertex = '0;
      for (int i = 0; i < NV; i++) begin
         tri_res.vertex[i] = vertex_ff[i];
      end
      tri_res.kind   = bmtp_pkg::KIND_TRIANGLE;
      tri_res.number = done_ff[31:0];
      tri_res.last   = 1'b0;

      status_res.vertex = '0;
      status_res.last   = 1'b1;
      if (!size_ok) begin
         status_res.kind   = bmtp_pkg::KIND_SIZE_ERROR;
         status_res.number = '0;
      end else if (bad_in) begin
         status_res.kind   = bmtp_pkg::KIND_NONFINITE;
         status_res.number = bad_idx_in;
      end else begin
         status_res.kind   = bmtp_pkg::KIND_SUCCESS;
         status_res.number = '0;
      end

      if (req_tlast) begin
         prefix_in  = '0;
         record_in  = '0;
         count_in   = '0;
         done_in    = '0;
         gather_in  = '0;
         bad_in     = 1'b0;
         bad_idx_in = '0;
      end

      push.first_valid  = accept & (tri_valid | req_tlast);
      push.second_valid = accept & tri_valid & req_tlast;
      push.first        = tri_valid ? tri_res : status_res;
      push.second       = status_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff  <= '0;
         record_ff  <= '0;
         count_ff   <= '0;
         done_ff    <= '0;
         gather_ff  <= '0;
         bad_ff     <= 1'b0;
         bad_idx_ff <= '0;
      end else if (accept) begin
         prefix_ff  <= prefix_in;
         record_ff  <= record_in;
         count_ff   <= count_in;
         done_ff    <= done_in;
         gather_ff  <= gather_in;
         bad_ff     <= bad_in;
         bad_idx_ff <= bad_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < NV; i++) begin
            vertex_ff[i] <= vertex_in[i];
         end
      end
   end

   bmtp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {head.number, head.vertex};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

[tb/binary_mesh_triangle_parser_tb.sv]
`timescale 1ns / 1ps
// binary_mesh_triangle_parser_tb: feeds byte streams of binary mesh files into the parser
// and checks every triangle and status against a byte-level model of the file layout.
// Depends on bmtp_pkg and binary_mesh_triangle_parser.
module binary_mesh_triangle_parser_tb;

   localparam int HEADER_LEN   = 80;
   localparam int PREFIX_LEN   = HEADER_LEN + 4;
   localparam int RECORD_LEN   = 50;
   localparam int NORMAL_LEN   = 12;
   localparam int VERTEX_STOP  = NORMAL_LEN + 36;
   localparam int TOTAL_BYTES  = 1950;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic [8:0][31:0]   vertex;
      bmtp_pkg::kind_type kind;
      logic [31:0]        number;
      logic               last;
   } mesh_result_type;

   class mesh_parse_model;
      logic [6:0]       prefix_pos;
      logic [5:0]       record_pos;
      logic [31:0]      declared;
      logic [32:0]      completed;
      logic [23:0]      gather;
      logic [8:0][31:0] words;
      logic             bad_seen;
      logic [31:0]      bad_index;
      mesh_result_type  awaited[$];
      int               errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         prefix_pos = '0;
         record_pos = '0;
         declared   = '0;
         completed  = '0;
         gather     = '0;
         words      = '0;
         bad_seen   = 1'b0;
         bad_index  = '0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void push(logic [8:0][31:0] v, bmtp_pkg::kind_type k, logic [31:0] num,
                         logic l);
         mesh_result_type r;
         r.vertex = v;
         r.kind   = k;
         r.number = num;
         r.last   = l;
         awaited.push_back(r);
      endfunction

      function void note_request(logic [7:0] b, logic l);
         int  k;
         int  p;
         bit  fin;
         logic size_ok;
         if (prefix_pos < PREFIX_LEN) begin
            if (prefix_pos >= HEADER_LEN) begin
               if (prefix_pos == PREFIX_LEN - 1) declared = {b, gather};
               else gather = {b, gather[23:8]};
            end
            prefix_pos++;
         end else begin
            p = record_pos;
            if (p >= NORMAL_LEN && p < VERTEX_STOP) begin
               k = p - NORMAL_LEN;
               if ((k % 4) == 3) words[k / 4] = {b, gather};
               else gather = {b, gather[23:8]};
            end
            if (p + 1 >= RECORD_LEN) begin
               record_pos = '0;
               if (!bad_seen) begin
                  fin = 1;
                  for (int i = 0; i < 9; i++)
                     if (words[i][30:23] == 8'hFF) fin = 0;
                  if (fin) begin
                     push(words, bmtp_pkg::KIND_TRIANGLE, completed[31:0], 1'b0);
                  end else begin
                     bad_seen  = 1'b1;
                     bad_index = completed[31:0];
                  end
               end
               if (completed != {33{1'b1}}) completed++;
            end else begin
               record_pos = 6'(p + 1);
            end
         end
         if (l) begin
            size_ok = (prefix_pos >= PREFIX_LEN) && (record_pos == 0) &&
                      (completed == {1'b0, declared});
            if (!size_ok) push('0, bmtp_pkg::KIND_SIZE_ERROR, '0, 1'b1);
            else if (bad_seen) push('0, bmtp_pkg::KIND_NONFINITE, bad_index, 1'b1);
            else push('0, bmtp_pkg::KIND_SUCCESS, '0, 1'b1);
            clear();
         end
      endfunction

      function void match_result(logic [319:0] data, logic [1:0] kind, logic l);
         mesh_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: kind %0d number %0d last %0b vertices %h",
                        kind, data[319:288], l, data[287:0]);
            return;
         end
         want = awaited.pop_front();
         if (want.vertex !== data[287:0] || want.kind !== kind ||
             want.number !== data[319:288] || want.last !== l) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch expected: kind %0d number %0d last %0b vertices %h",
                        want.kind, want.number, want.last, want.vertex);
               $display("         actual:   kind %0d number %0d last %0b vertices %h",
                        kind, data[319:288], l, data[287:0]);
            end
         end
      endfunction
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;   // [7:0] data_byte
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [319:0] rsp_tdata;         // v0_x, v0_y, v0_z, v1_x .. v2_z, triangle_number
   logic [1:0]   rsp_tuser;         // [1:0] result_kind
   logic         rsp_tlast;

   mesh_parse_model parse = new();
   logic [7:0]      file_bytes[$];
   bit              steady = 0;
   int              cycles = 0;

   binary_mesh_triangle_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic bit idle_now();
      return !steady && ($urandom_range(0, 99) < 15);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         parse.match_result(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= !reset && !idle_now();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic l);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse.note_request(b, l);
   endtask

   task automatic send_file(inout int count_sent);
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      count_sent += file_bytes.size();
      file_bytes.delete();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (parse.pending() != 0) @(posedge clock);
   endtask

   function automatic void add_header(logic [31:0] count);
      for (int i = 0; i < HEADER_LEN; i++) file_bytes.push_back($urandom_range(0, 255));
      for (int i = 0; i < 4; i++) file_bytes.push_back(count[8*i +: 8]);
   endfunction

   function automatic void add_record(logic [8:0][31:0] v);
      for (int i = 0; i < NORMAL_LEN; i++) file_bytes.push_back($urandom_range(0, 255));
      for (int w = 0; w < 9; w++)
         for (int i = 0; i < 4; i++) file_bytes.push_back(v[w][8*i +: 8]);
      for (int i = 0; i < 2; i++) file_bytes.push_back($urandom_range(0, 255));
   endfunction

   function automatic logic [8:0][31:0] random_vertices();
      logic [8:0][31:0] v;
      int               sel;
      for (int w = 0; w < 9; w++) begin
         v[w] = $urandom;
         sel  = $urandom_range(0, 99);
         if (sel == 0) v[w][30:23] = 8'hFF;
         else if (sel < 4) v[w][30:23] = 8'hFE;
         else if (sel < 6) v[w][30:23] = 8'h00;
      end
      return v;
   endfunction

   function automatic void cut_file(int keep);
      while (file_bytes.size() > keep) file_bytes.delete(file_bytes.size() - 1);
   endfunction

   initial begin
      logic [8:0][31:0] v;
      int               sent;
      int               n;
      int               sel;
      int               files;
      logic [31:0]      count;
      sent  = 0;
      files = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short file, one byte
      file_bytes.push_back(8'hFF);
      send_file(sent);
      // ends inside the count
      add_header(32'd0);
      cut_file(82);
      send_file(sent);
      // empty mesh
      add_header(32'd0);
      send_file(sent);
      // one triangle with extreme finite values
      v    = {9{32'h7F7FFFFF}};
      v[0] = 32'h00000000;
      v[4] = 32'h80000000;
      v[8] = 32'hFF7FFFFF;
      add_header(32'd1);
      add_record(v);
      send_file(sent);
      // infinite coordinate in the second triangle
      add_header(32'd2);
      add_record({9{32'h3F800000}});
      v    = {9{32'h3F800000}};
      v[5] = 32'h7F800000;
      add_record(v);
      send_file(sent);
      // records beyond the count
      add_header(32'd1);
      add_record(random_vertices());
      add_record({9{32'hC2C80000}});
      send_file(sent);
      // ends inside a record
      add_header(32'd1);
      add_record({9{32'h40490FDB}});
      cut_file(PREFIX_LEN + 30);
      send_file(sent);
      // nan plus size mismatch
      v    = {9{32'h3F000000}};
      v[0] = 32'hFFFFFFFF;
      add_header(32'd2);
      add_record(v);
      send_file(sent);
      // huge declared count
      add_header(32'hFFFFFFFF);
      send_file(sent);
      drain();

      while (sent < TOTAL_BYTES) begin
         steady = (files >= 1 && files < 4);
         sel    = $urandom_range(0, 99);
         if (sel < 8) begin
            n = $urandom_range(1, 90);
            repeat (n) file_bytes.push_back($urandom_range(0, 255));
         end else if (sel < 70) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
            add_header(n);
            repeat (n) add_record(random_vertices());
         end else begin
            n = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
               0: count = n + 1;
               1: count = (n > 0) ? n - 1 : $urandom;
               2: count = $urandom;
               default: count = n;
            endcase
            add_header(count);
            repeat (n) add_record(random_vertices());
            if (count == n || $urandom_range(0, 1) == 1)
               cut_file($urandom_range(1, file_bytes.size() - 1));
         end
         send_file(sent);
         files++;
         if ($urandom_range(0, 9) == 0) drain();
      end
      steady = 0;
      req_tvalid <= 1'b0;

      while (parse.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (parse.errors == 0 && parse.pending() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
